### rtl/tpwm_pkg.sv
`timescale 1ns / 1ps
package tpwm_pkg;

	localparam int PRESCALE_BITS = 10;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 8;

	// operation codes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_CLR_OVF = 2'd2;
	localparam logic [1:0] OP_CLR_CMP = 2'd3;

	// waveform modes
	localparam logic [1:0] WM_NORMAL = 2'd0;
	localparam logic [1:0] WM_PC_PWM = 2'd1;
	localparam logic [1:0] WM_CTC    = 2'd2;
	localparam logic [1:0] WM_FAST   = 2'd3;

	// compare output modes
	localparam logic [1:0] OM_OFF    = 2'd0;
	localparam logic [1:0] OM_TOGGLE = 2'd1;
	localparam logic [1:0] OM_CLEAR  = 2'd2;
	localparam logic [1:0] OM_SET    = 2'd3;

	// clock select codes
	localparam logic [2:0] CS_STOP     = 3'd0;
	localparam logic [2:0] CS_DIV1     = 3'd1;
	localparam logic [2:0] CS_DIV8     = 3'd2;
	localparam logic [2:0] CS_DIV64    = 3'd3;
	localparam logic [2:0] CS_DIV256   = 3'd4;
	localparam logic [2:0] CS_DIV1024  = 3'd5;
	localparam logic [2:0] CS_PIN_FALL = 3'd6;
	localparam logic [2:0] CS_PIN_RISE = 3'd7;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLOCK    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COMPARE  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OVF_IE   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CMP_IE   = 3'd5;

	typedef struct packed {
		logic [1:0] operation;
		logic       ext_pin_level;
		logic [7:0] write_value;
	} item_t;

	typedef struct packed {
		logic [7:0] count_value;
		logic       wave_out;
		logic       overflow_flag;
		logic       compare_flag;
		logic       irq;
	} result_t;

	// prescaler bits that must all be ones for a divided timer clock
	function automatic logic [PRESCALE_BITS-1:0] div_mask(input logic [2:0] cs);
		logic [PRESCALE_BITS-1:0] m;
		begin
			case (cs)
				CS_DIV8:    m = 10'h007;
				CS_DIV64:   m = 10'h03F;
				CS_DIV256:  m = 10'h0FF;
				CS_DIV1024: m = 10'h3FF;
				default:    m = 10'h000;
			endcase
			return m;
		end
	endfunction

endpackage

### rtl/eight_bit_timer_pwm_unit.sv
`timescale 1ns / 1ps
// Timer/counter with compare output and PWM.
// Item channel (item, item_valid, item_stall): one word per system tick or
// register access: a clock tick, a counter write, or a flag clear.
// Result channel (result, result_valid, result_stall): one word per item with
// the counter, the compare output pin level, both flags and irq.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always
// ready; write only while no item is in flight.
// Path: an accepted word is held in the input register, and its result is
// loaded into the result register once that register is empty or its word
// is being taken, so a receiver stall can hold the word in between.
// Throughput: one item per cycle without a receiver stall; counter, prescaler
// and flags update in combinational logic between input and result registers.
// When the receiver stalls, the result register holds its word and one more
// item may be taken into the input register; item_stall then rises.
// Reset clears the prescaler, counter, direction, output level, flags,
// configuration and both valid bits.
module eight_bit_timer_pwm_unit #(
	parameter int COUNT_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tpwm_pkg::item_t                   item,
	input  logic                              item_valid,
	output logic                              item_stall,
	output tpwm_pkg::result_t                 result,
	output logic                              result_valid,
	input  logic                              result_stall,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tpwm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tpwm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import tpwm_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [1:0] wm_q, om_q;
	logic [2:0] cs_q;
	logic [7:0] cmp_val_q;
	logic       ovf_ie_q, cmp_ie_q;

	logic [PRESCALE_BITS-1:0] ps_q, ps_n;
	logic [COUNT_BITS-1:0]    cnt_q, cnt_n;
	logic down_q, down_n, wave_q, wave_n, ovf_q, ovf_n, cmpf_q, cmpf_n, pin_q, pin_n;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;

	logic fire, accept, tick_en, match, up_edge, connected;
	logic [PRESCALE_BITS-1:0] mask;

	assign fire       = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && res_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;
	assign result       = res_q;
	assign result_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm_q      <= WM_NORMAL;
			om_q      <= OM_OFF;
			cs_q      <= CS_STOP;
			cmp_val_q <= 8'd0;
			ovf_ie_q  <= 1'b0;
			cmp_ie_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WAVEFORM: wm_q      <= cfg_data[1:0];
				REG_OUTPUT:   om_q      <= cfg_data[1:0];
				REG_CLOCK:    cs_q      <= cfg_data[2:0];
				REG_COMPARE:  cmp_val_q <= cfg_data;
				REG_OVF_IE:   ovf_ie_q  <= cfg_data[0];
				REG_CMP_IE:   cmp_ie_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign mask  = div_mask(cs_q);
	assign match = (cnt_q == COUNT_BITS'(cmp_val_q));

	always_comb begin
		case (cs_q)
			CS_STOP:     tick_en = 1'b0;
			CS_PIN_FALL: tick_en = pin_q && !item_s1.ext_pin_level;
			CS_PIN_RISE: tick_en = !pin_q && item_s1.ext_pin_level;
			default:     tick_en = ((ps_q & mask) == mask);
		endcase
	end

	always_comb begin
		ps_n    = ps_q;
		cnt_n   = cnt_q;
		down_n  = down_q;
		wave_n  = wave_q;
		ovf_n   = ovf_q;
		cmpf_n  = cmpf_q;
		pin_n   = pin_q;
		up_edge = 1'b0;
		case (item_s1.operation)
			OP_TICK: begin
				ps_n  = ps_q + PRESCALE_BITS'(1);
				pin_n = item_s1.ext_pin_level;
				if (tick_en) begin
					case (wm_q)
						WM_NORMAL, WM_CTC: begin
							if (wm_q == WM_CTC && match)
								cnt_n = '0;
							else
								cnt_n = cnt_q + COUNT_BITS'(1);
							if (cnt_q == CNT_MAX)
								ovf_n = 1'b1;
							if (match) begin
								cmpf_n = 1'b1;
								case (om_q)
									OM_TOGGLE: wave_n = !wave_q;
									OM_CLEAR:  wave_n = 1'b0;
									OM_SET:    wave_n = 1'b1;
									default: ;
								endcase
							end
						end
						WM_FAST: begin
							cnt_n = cnt_q + COUNT_BITS'(1);
							if (match) begin
								cmpf_n = 1'b1;
								if (om_q == OM_CLEAR)
									wave_n = 1'b0;
								else if (om_q == OM_SET)
									wave_n = 1'b1;
							end
							// bottom action wins over a match on the same clock
							if (cnt_q == CNT_MAX) begin
								ovf_n = 1'b1;
								if (om_q == OM_CLEAR)
									wave_n = 1'b1;
								else if (om_q == OM_SET)
									wave_n = 1'b0;
							end
						end
						default: begin
							if (!down_q) begin
								if (cnt_q == CNT_MAX) begin
									down_n = 1'b1;
									cnt_n  = cnt_q - COUNT_BITS'(1);
								end else begin
									cnt_n   = cnt_q + COUNT_BITS'(1);
									up_edge = 1'b1;
								end
							end else begin
								if (cnt_q == '0) begin
									down_n  = 1'b0;
									cnt_n   = COUNT_BITS'(1);
									up_edge = 1'b1;
									ovf_n   = 1'b1;
								end else begin
									cnt_n = cnt_q - COUNT_BITS'(1);
								end
							end
							if (match) begin
								cmpf_n = 1'b1;
								if (om_q == OM_CLEAR)
									wave_n = !up_edge;
								else if (om_q == OM_SET)
									wave_n = up_edge;
							end
						end
					endcase
				end
			end
			OP_WRITE:   cnt_n  = COUNT_BITS'(item_s1.write_value);
			OP_CLR_OVF: ovf_n  = 1'b0;
			default:    cmpf_n = 1'b0;
		endcase
	end

	// toggle is reserved in the PWM modes and leaves the pin disconnected
	assign connected = (om_q != OM_OFF) &&
		!(om_q == OM_TOGGLE && (wm_q == WM_PC_PWM || wm_q == WM_FAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			ps_q        <= '0;
			cnt_q       <= '0;
			down_q      <= 1'b0;
			wave_q      <= 1'b0;
			ovf_q       <= 1'b0;
			cmpf_q      <= 1'b0;
			pin_q       <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
			if (fire) begin
				res_valid_q <= 1'b1;
				ps_q        <= ps_n;
				cnt_q       <= cnt_n;
				down_q      <= down_n;
				wave_q      <= wave_n;
				ovf_q       <= ovf_n;
				cmpf_q      <= cmpf_n;
				pin_q       <= pin_n;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
		if (fire) begin
			res_q.count_value   <= cnt_n[7:0];
			res_q.wave_out      <= connected && wave_n;
			res_q.overflow_flag <= ovf_n;
			res_q.compare_flag  <= cmpf_n;
			res_q.irq           <= (ovf_n && ovf_ie_q) || (cmpf_n && cmp_ie_q);
		end
	end

endmodule

### bench/timer_pwm_checker.sv
`timescale 1ns / 1ps
module timer_pwm_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tpwm_pkg::item_t                     item,
	input  logic                                item_valid,
	input  logic                                item_stall,
	input  tpwm_pkg::result_t                   result,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [tpwm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tpwm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                  fail_count,
	output int                                  pending_results
);
	import tpwm_pkg::*;

	// shadow copy of the timer
	logic [PRESCALE_BITS-1:0] presc;
	logic [7:0] cnt;
	logic       down;
	logic       wave;
	logic       ovf;
	logic       cmpf;
	logic       last_pin;

	logic [1:0] wm;
	logic [1:0] om;
	logic [2:0] cs;
	logic [7:0] cmp_val;
	logic       ovf_ie;
	logic       cmp_ie;

	result_t timer_words_due[$];
	result_t want;
	int      mismatch_count;

	// one timer clock: decisions use the counter value before the clock
	function automatic void timer_clock_step();
		logic [7:0] prev;
		logic       hit;
		logic       climbing;
		prev = cnt;
		hit = (prev == cmp_val);
		climbing = 1'b0;
		case (wm)
			WM_NORMAL, WM_CTC: begin
				cnt = (wm == WM_CTC && hit) ? 8'd0 : prev + 8'd1;
				if (prev == 8'hFF)
					ovf = 1'b1;
				if (hit) begin
					cmpf = 1'b1;
					case (om)
						OM_TOGGLE: wave = ~wave;
						OM_CLEAR:  wave = 1'b0;
						OM_SET:    wave = 1'b1;
						default: ;
					endcase
				end
			end
			WM_FAST: begin
				cnt = prev + 8'd1;
				if (hit) begin
					cmpf = 1'b1;
					if (om == OM_CLEAR)
						wave = 1'b0;
					else if (om == OM_SET)
						wave = 1'b1;
				end
				// bottom action wins over a match on the same clock
				if (prev == 8'hFF) begin
					ovf = 1'b1;
					if (om == OM_CLEAR)
						wave = 1'b1;
					else if (om == OM_SET)
						wave = 1'b0;
				end
			end
			default: begin
				if (!down) begin
					if (prev == 8'hFF) begin
						down = 1'b1;
						cnt = prev - 8'd1;
					end else begin
						cnt = prev + 8'd1;
						climbing = 1'b1;
					end
				end else begin
					if (prev == 8'd0) begin
						down = 1'b0;
						cnt = 8'd1;
						climbing = 1'b1;
						ovf = 1'b1;
					end else begin
						cnt = prev - 8'd1;
					end
				end
				if (hit) begin
					cmpf = 1'b1;
					if (om == OM_CLEAR)
						wave = ~climbing;
					else if (om == OM_SET)
						wave = climbing;
				end
			end
		endcase
	endfunction

	function automatic result_t predict_timer_word(input item_t w);
		result_t                  r;
		logic                     tmr_en;
		logic [PRESCALE_BITS-1:0] mask;
		logic                     conn;
		tmr_en = 1'b0;
		case (w.operation)
			OP_TICK: begin
				case (cs)
					CS_DIV8:    mask = 10'h007;
					CS_DIV64:   mask = 10'h03F;
					CS_DIV256:  mask = 10'h0FF;
					CS_DIV1024: mask = 10'h3FF;
					default:    mask = 10'h000;
				endcase
				if (cs >= CS_DIV1 && cs <= CS_DIV1024)
					tmr_en = ((presc & mask) == mask);
				else if (cs == CS_PIN_FALL)
					tmr_en = last_pin && !w.ext_pin_level;
				else if (cs == CS_PIN_RISE)
					tmr_en = !last_pin && w.ext_pin_level;
				presc = presc + 1'b1;
				last_pin = w.ext_pin_level;
				if (tmr_en)
					timer_clock_step();
			end
			OP_WRITE:   cnt = w.write_value;
			OP_CLR_OVF: ovf = 1'b0;
			default:    cmpf = 1'b0;
		endcase
		// toggle is reserved in the PWM modes and leaves the pin off
		conn = (om != OM_OFF) && !(om == OM_TOGGLE && (wm == WM_PC_PWM || wm == WM_FAST));
		r.count_value = cnt;
		r.wave_out = conn & wave;
		r.overflow_flag = ovf;
		r.compare_flag = cmpf;
		r.irq = (ovf & ovf_ie) | (cmpf & cmp_ie);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc = '0;
			cnt = '0;
			down = 1'b0;
			wave = 1'b0;
			ovf = 1'b0;
			cmpf = 1'b0;
			last_pin = 1'b0;
			wm = WM_NORMAL;
			om = OM_OFF;
			cs = CS_STOP;
			cmp_val = '0;
			ovf_ie = 1'b0;
			cmp_ie = 1'b0;
			timer_words_due.delete();
			mismatch_count = 0;
			fail_count <= 0;
			pending_results <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WAVEFORM: wm = cfg_data[1:0];
					REG_OUTPUT:   om = cfg_data[1:0];
					REG_CLOCK:    cs = cfg_data[2:0];
					REG_COMPARE:  cmp_val = cfg_data;
					REG_OVF_IE:   ovf_ie = cfg_data[0];
					REG_CMP_IE:   cmp_ie = cfg_data[0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (timer_words_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result word: cnt=%h wave=%b ovf=%b cmp=%b irq=%b",
							result.count_value, result.wave_out, result.overflow_flag,
							result.compare_flag, result.irq);
					mismatch_count++;
				end else begin
					want = timer_words_due.pop_front();
					if (result !== want) begin
						if (mismatch_count < 10)
							$display({"result mismatch: expected cnt=%h wave=%b ovf=%b cmp=%b",
								" irq=%b, got cnt=%h wave=%b ovf=%b cmp=%b irq=%b"},
								want.count_value, want.wave_out, want.overflow_flag,
								want.compare_flag, want.irq,
								result.count_value, result.wave_out, result.overflow_flag,
								result.compare_flag, result.irq);
						mismatch_count++;
					end
				end
			end
			if (item_valid && !item_stall)
				timer_words_due.push_back(predict_timer_word(item));
			pending_results <= timer_words_due.size();
			fail_count <= mismatch_count;
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import tpwm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 64;
	localparam int SEGMENTS = 10;
	localparam int WORDS_PER_SEGMENT = 52;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	item_t   item = '0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall = 1'b0;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	int fail_count;
	int pending_results;

	int send_idle = 27;
	int recv_idle = 62;
	int hold_requests = 0;
	logic [7:0] cur_compare = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	eight_bit_timer_pwm_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.result(result),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	timer_pwm_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.result(result),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_results(pending_results)
	);

	function automatic item_t make_word(input logic [1:0] op, input logic pin,
		input logic [7:0] v);
		item_t w;
		w.operation = op;
		w.ext_pin_level = pin;
		w.write_value = v;
		return w;
	endfunction

	function automatic item_t random_word();
		int         pick;
		logic [1:0] op;
		logic [7:0] v;
		pick = $urandom_range(99);
		if (pick < 70)
			op = OP_TICK;
		else if (pick < 82)
			op = OP_WRITE;
		else if (pick < 91)
			op = OP_CLR_OVF;
		else
			op = OP_CLR_CMP;
		// counter loads near the compare value, the top or the bottom reach events quickly
		case ($urandom_range(2))
			0: v = cur_compare - 8'($urandom_range(3));
			1: v = $urandom_range(1) ? 8'hFF - 8'($urandom_range(3)) : 8'($urandom_range(3));
			default: v = 8'($urandom);
		endcase
		return make_word(op, 1'($urandom_range(1)), v);
	endfunction

	task automatic send_word(input item_t w);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_config(input logic [1:0] wmode, input logic [1:0] omode,
		input logic [2:0] csel, input logic [7:0] cmpv, input logic oie, input logic cie);
		put_reg(REG_WAVEFORM, {6'd0, wmode});
		put_reg(REG_OUTPUT, {6'd0, omode});
		put_reg(REG_CLOCK, {5'd0, csel});
		put_reg(REG_COMPARE, cmpv);
		put_reg(REG_OVF_IE, {7'd0, oie});
		put_reg(REG_CMP_IE, {7'd0, cie});
		cfg_valid <= 1'b0;
		cur_compare = cmpv;
	endtask

	task automatic random_config();
		int         pick;
		logic [2:0] csel;
		logic [7:0] cmpv;
		pick = $urandom_range(99);
		if (pick < 40)
			csel = CS_DIV1;
		else if (pick < 70)
			csel = $urandom_range(1) ? CS_PIN_FALL : CS_PIN_RISE;
		else
			csel = 3'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 25)
			cmpv = 8'h00;
		else if (pick < 50)
			cmpv = 8'hFF;
		else
			cmpv = 8'($urandom_range(255));
		load_config(2'($urandom_range(3)), 2'($urandom_range(3)), csel, cmpv,
			1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int mode;
		int seg;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// normal mode: compare toggle, overflow, both flag clears
		load_config(WM_NORMAL, OM_TOGGLE, CS_DIV1, 8'd2, 1'b1, 1'b1);
		send_word(make_word(OP_TICK, 1'b0, 8'h00));
		send_word(make_word(OP_TICK, 1'b1, 8'hFF));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));
		send_word(make_word(OP_WRITE, 1'b1, 8'hFF));
		send_word(make_word(OP_TICK, 1'b1, 8'h00));
		send_word(make_word(OP_CLR_OVF, 1'b0, 8'hAA));
		send_word(make_word(OP_CLR_CMP, 1'b1, 8'h55));

		// fast PWM inverting, compare at top: bottom clear wins over the match set
		wait_idle();
		load_config(WM_FAST, OM_SET, CS_PIN_RISE, 8'hFF, 1'b0, 1'b1);
		send_word(make_word(OP_WRITE, 1'b0, 8'hFE));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));
		send_word(make_word(OP_TICK, 1'b1, 8'h00));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));
		send_word(make_word(OP_TICK, 1'b1, 8'h00));

		// phase-correct: match going up, turn at top, match going down
		wait_idle();
		load_config(WM_PC_PWM, OM_CLEAR, CS_DIV1, 8'hFE, 1'b1, 1'b0);
		send_word(make_word(OP_WRITE, 1'b0, 8'hFE));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));

		// CTC restart at compare
		wait_idle();
		load_config(WM_CTC, OM_CLEAR, CS_DIV1, 8'd1, 1'b0, 1'b0);
		send_word(make_word(OP_WRITE, 1'b0, 8'h00));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));

		// toggle is reserved in fast PWM; stopped clock holds the counter
		wait_idle();
		load_config(WM_FAST, OM_TOGGLE, CS_STOP, 8'd0, 1'b1, 1'b1);
		send_word(make_word(OP_TICK, 1'b1, 8'h00));
		send_word(make_word(OP_TICK, 1'b0, 8'h00));

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle = 27;
					recv_idle = 62;
				end
				1: begin
					send_idle = 62;
					recv_idle = 27;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (seg = 0; seg < SEGMENTS; seg++) begin
				wait_idle();
				random_config();
				if (seg == 3)
					hold_requests++;
				repeat (WORDS_PER_SEGMENT) send_word(random_word());
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
